/* rtl/core/d2f_rd_pkg.sv */
package d2f_rd_pkg;

  localparam int unsigned DblWidth  = 64;
  localparam int unsigned FltWidth  = 32;
  localparam logic [10:0] DblExpAll = 11'h7ff;
  localparam logic [11:0] ExpOffset = 12'd896;   // 1023 - 127
  localparam logic [11:0] FltExpMax = 12'd254;
  localparam logic [22:0] FltMantAll = 23'h7fffff;
  localparam logic [31:0] FltMinNeg = 32'h80800000;

  // Result of one conversion
  typedef struct packed {
    logic [FltWidth-1:0] float_bits;
    logic                status;
  } d2f_res_t;

  // Convert one double pattern, rounding toward minus infinity
  function automatic d2f_res_t d2f_convert(logic [DblWidth-1:0] v);
    d2f_res_t    r;
    logic        neg;
    logic [10:0] dexp;
    logic [51:0] mant;
    logic [11:0] fexp;
    logic [22:0] m23;
    logic        rem_nz;
    logic [30:0] mag;
    neg    = v[63];
    dexp   = v[62:52];
    mant   = v[51:0];
    m23    = mant[51:29];
    rem_nz = |mant[28:0];
    fexp   = {1'b0, dexp} - ExpOffset;
    mag    = {fexp[7:0], m23};
    r.float_bits = '0;
    r.status     = 1'b0;
    if (dexp == DblExpAll) begin
      r.status = 1'b1;
    end else if ({1'b0, dexp} <= ExpOffset) begin
      if (neg && (dexp != 11'd0 || mant != 52'd0)) r.float_bits = FltMinNeg;
    end else if (fexp > FltExpMax) begin
      r.status = 1'b1;
    end else if (fexp == FltExpMax && m23 == FltMantAll && rem_nz) begin
      r.status = 1'b1;
    end else if (neg) begin
      r.float_bits = {1'b1, mag + {30'd0, rem_nz}};
    end else begin
      r.float_bits = {1'b0, mag};
    end
    return r;
  endfunction

endpackage

/* rtl/core/d2f_rd_stage.sv */
module d2f_rd_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [d2f_rd_pkg::DblWidth-1:0]   value_bits_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output d2f_rd_pkg::d2f_res_t              res_o
);
  import d2f_rd_pkg::*;

  logic     in_valid_q;
  logic [DblWidth-1:0] in_data_q;
  logic     out_valid_q;
  d2f_res_t out_q, out_d;
  logic     adv_out, adv_in;

  // Advance when the result register is free or being drained
  assign adv_out = in_valid_q && (!out_valid_q || ready_i);
  assign adv_in  = !in_valid_q || adv_out;
  assign ready_o = adv_in;
  assign out_d   = d2f_convert(in_data_q);

  // Hold the input word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv_in) begin
      in_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && valid_i) in_data_q <= value_bits_i;
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= 1'b1;
    end else if (ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) out_q <= out_d;
  end

  assign valid_o = out_valid_q;
  assign res_o   = out_q;
endmodule

/* rtl/core/double_to_float_round_down_core.sv */
// Channel | Direction | Signals
// input   | in        | valid_i, ready_o, value_bits_i[63:0]
// output  | out       | valid_o, ready_i, float_bits_o[31:0], status_o
//
// Two registers lie in the path: input register, then result register.
// One word is taken every cycle while the output side keeps up.
// Reset clears both valid flags; data registers are not reset.
// A stall on the output holds the result and fills the input register.
module double_to_float_round_down_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] value_bits_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] float_bits_o,
  output logic        status_o
);
  import d2f_rd_pkg::*;

  d2f_res_t res;

  d2f_rd_stage u_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .ready_o     (ready_o),
    .value_bits_i(value_bits_i),
    .valid_o     (valid_o),
    .ready_i     (ready_i),
    .res_o       (res)
  );

  assign float_bits_o = res.float_bits;
  assign status_o     = res.status;
endmodule
